// ===== rtl/core/lxrg_pkg.sv =====
// Shared types and constants for the lagged XOR random generator.
// Used by lagged_xor_random_generator and lxrg_checker; depends on nothing.
package lxrg_pkg;

    // Request codes carried on the slave-side tuser
    typedef enum logic [1:0] {
        REQ_SEED   = 2'd0,
        REQ_RAW    = 2'd1,
        REQ_RANGED = 2'd2
    } t_req;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_J,
        ST_SEED_S,
        ST_READ,
        ST_UPDATE,
        ST_DIVIDE,
        ST_SUM,
        ST_DONE
    } t_state;

    // Field widths
    localparam int DATA_W   = 32;
    localparam int WORD_W   = 31;
    localparam int REQ_W    = 2;
    localparam int IN_DATA_W = 3 * DATA_W;

    // Remainder unit: one quotient bit per step over the drawn word
    localparam int DIV_STEPS = WORD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Seed generator: x' = x * LCG_MUL + LCG_ADD mod 2^32
    localparam logic [DATA_W-1:0] LCG_MUL = 32'h41C6_4E6D;
    localparam logic [DATA_W-1:0] LCG_ADD = 32'h0000_3039;

endpackage

// ===== rtl/core/lagged_xor_random_generator.sv =====
// Lagged XOR random generator: table memory, seed multiplier, remainder unit, sequencer.
// Depends on lxrg_pkg.
//
//  channel   dir  tdata (low bit first)                      tuser
//  s_axis    in   seed_value, range_low, range_high (96b)    req_type (2b)
//  m_axis    out  value (32b)                                range_error (1b)
//
// A ranged draw steps through read, write back, 31 steps of the one-bit-per-cycle
// restoring remainder unit, add and hand-off; a raw draw through read, write back and hand-off.
// A reseed writes each entry in two steps, SEED_J and SEED_S, through the single
// seed multiplier. An empty range and the unused code go straight to hand-off, which
// waits for a free output register. The next accept can come in the cycle after the result is loaded.
// Reset clears the entry valid bits, so the whole table reads as zero with no sweep.
// s_axis_tready is high only while the sequencer idles; a result waits in the output
// register, and the block accepts the next item meanwhile.
module lagged_xor_random_generator #(
    parameter int TABLE_SIZE = 249,
    parameter int TAP_START  = 103
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [31:0] seed_value, [63:32] range_low, [95:64] range_high
    input  logic [lxrg_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [lxrg_pkg::REQ_W-1:0]    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] value
    output logic [lxrg_pkg::DATA_W-1:0]   m_axis_tdata,
    // [0] range_error
    output logic [0:0]                    m_axis_tuser
);

    localparam int PTR_W    = $clog2(TABLE_SIZE);
    localparam int TAP_INIT = TAP_START % TABLE_SIZE;
    localparam int DW       = lxrg_pkg::DATA_W;
    localparam int WW       = lxrg_pkg::WORD_W;

    // Table memory and its registered read ports
    logic [WW-1:0]         mem [TABLE_SIZE];
    logic [WW-1:0]         r_rd_a;
    logic [WW-1:0]         r_rd_b;
    logic                  r_va;
    logic                  r_vb;
    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;
    logic [WW-1:0]         wr_data;

    // Control and payload registers
    lxrg_pkg::t_state      r_state, n_state;
    lxrg_pkg::t_req        r_req, n_req;
    logic [TABLE_SIZE-1:0] r_valid, n_valid;
    logic [PTR_W-1:0]      r_rdp, n_rdp;
    logic [PTR_W-1:0]      r_tap, n_tap;
    logic [PTR_W-1:0]      r_idx, n_idx;
    logic [DW-1:0]         r_lcg, n_lcg;
    logic [15:0]           r_jlo, n_jlo;
    logic [DW-1:0]         r_lo, n_lo;
    logic [DW-1:0]         r_span, n_span;
    logic [WW-1:0]         r_word, n_word;
    logic [DW-1:0]         r_rem, n_rem;
    logic [lxrg_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [DW-1:0]         r_result, n_result;
    logic                  r_err, n_err;
    logic                  r_out_valid, n_out_valid;
    logic [DW-1:0]         r_out_value, n_out_value;
    logic                  r_out_err, n_out_err;

    // Datapath helpers
    logic signed [DW-1:0]  in_lo;
    logic signed [DW-1:0]  in_hi;
    logic [DW-1:0]         lcg_next;
    logic [DW:0]           trial;
    logic [WW-1:0]         drawn;
    logic                  accept;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign in_lo    = s_axis_tdata[2*DW-1:DW];
    assign in_hi    = s_axis_tdata[3*DW-1:2*DW];

    // Shared seed multiplier
    assign lcg_next = DW'(r_lcg * lxrg_pkg::LCG_MUL) + lxrg_pkg::LCG_ADD;

    // Restoring remainder step: shift in the next word bit
    assign trial    = {r_rem, r_word[WW-1]};

    // Entries never written read as zero
    assign drawn    = (r_va ? r_rd_a : '0) ^ (r_vb ? r_rd_b : '0);

    // Write and read the table
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_a <= mem[r_rdp];
        r_rd_b <= mem[r_tap];
        r_va   <= r_valid[r_rdp];
        r_vb   <= r_valid[r_tap];
    end

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lxrg_pkg::ST_IDLE;
            r_valid     <= '0;
            r_rdp       <= '0;
            r_tap       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_rdp       <= n_rdp;
            r_tap       <= n_tap;
            r_out_valid <= n_out_valid;
        end
        r_req       <= n_req;
        r_idx       <= n_idx;
        r_lcg       <= n_lcg;
        r_jlo       <= n_jlo;
        r_lo        <= n_lo;
        r_span      <= n_span;
        r_word      <= n_word;
        r_rem       <= n_rem;
        r_cnt       <= n_cnt;
        r_result    <= n_result;
        r_err       <= n_err;
        r_out_value <= n_out_value;
        r_out_err   <= n_out_err;
    end

    // Sequence requests
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_valid     = r_valid;
        n_rdp       = r_rdp;
        n_tap       = r_tap;
        n_idx       = r_idx;
        n_lcg       = r_lcg;
        n_jlo       = r_jlo;
        n_lo        = r_lo;
        n_span      = r_span;
        n_word      = r_word;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_result    = r_result;
        n_err       = r_err;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_err   = r_out_err;
        wr_en       = 1'b0;
        wr_addr     = r_rdp;
        wr_data     = drawn;

        // Drop the result once taken
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            lxrg_pkg::ST_IDLE: begin
                if (accept) begin
                    n_req    = lxrg_pkg::t_req'(s_axis_tuser);
                    n_lo     = in_lo;
                    n_span   = in_hi - in_lo;
                    n_result = '0;
                    n_err    = 1'b0;
                    case (lxrg_pkg::t_req'(s_axis_tuser))
                        lxrg_pkg::REQ_SEED: begin
                            n_lcg   = s_axis_tdata[DW-1:0];
                            n_idx   = '0;
                            n_state = lxrg_pkg::ST_SEED_J;
                        end
                        lxrg_pkg::REQ_RAW: begin
                            n_state = lxrg_pkg::ST_READ;
                        end
                        lxrg_pkg::REQ_RANGED: begin
                            if (in_hi <= in_lo) begin
                                n_result = in_lo;
                                n_err    = 1'b1;
                                n_state  = lxrg_pkg::ST_DONE;
                            end else begin
                                n_state  = lxrg_pkg::ST_READ;
                            end
                        end
                        default: begin
                            n_state = lxrg_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            // First seed step: keep the upper half as the low entry bits
            lxrg_pkg::ST_SEED_J: begin
                n_lcg   = lcg_next;
                n_jlo   = lcg_next[31:16];
                n_state = lxrg_pkg::ST_SEED_S;
            end

            // Second seed step: write the entry and advance
            lxrg_pkg::ST_SEED_S: begin
                n_lcg          = lcg_next;
                wr_en          = 1'b1;
                wr_addr        = r_idx;
                wr_data        = {lcg_next[30:16], r_jlo};
                n_valid[r_idx] = 1'b1;
                if (r_idx == PTR_W'(TABLE_SIZE - 1)) begin
                    n_rdp   = '0;
                    n_tap   = PTR_W'(TAP_INIT);
                    n_state = lxrg_pkg::ST_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = lxrg_pkg::ST_SEED_J;
                end
            end

            // Let the table read settle into its output registers
            lxrg_pkg::ST_READ: begin
                n_state = lxrg_pkg::ST_UPDATE;
            end

            // Write the new word back and advance both pointers
            lxrg_pkg::ST_UPDATE: begin
                wr_en          = 1'b1;
                n_valid[r_rdp] = 1'b1;
                n_rdp = (r_rdp == PTR_W'(TABLE_SIZE - 1)) ? '0 : r_rdp + 1'b1;
                n_tap = (r_tap == PTR_W'(TABLE_SIZE - 1)) ? '0 : r_tap + 1'b1;
                if (r_req == lxrg_pkg::REQ_RAW) begin
                    n_result = {1'b0, drawn};
                    n_state  = lxrg_pkg::ST_DONE;
                end else begin
                    n_word  = drawn;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = lxrg_pkg::ST_DIVIDE;
                end
            end

            // One remainder bit per cycle
            lxrg_pkg::ST_DIVIDE: begin
                n_word = {r_word[WW-2:0], 1'b0};
                if (trial >= {1'b0, r_span}) begin
                    n_rem = DW'(trial - {1'b0, r_span});
                end else begin
                    n_rem = trial[DW-1:0];
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == lxrg_pkg::CNT_W'(lxrg_pkg::DIV_STEPS - 1)) begin
                    n_state = lxrg_pkg::ST_SUM;
                end
            end

            // Offset the remainder by the lower bound
            lxrg_pkg::ST_SUM: begin
                n_result = r_lo + r_rem;
                n_state  = lxrg_pkg::ST_DONE;
            end

            // Load the output register once it is free
            lxrg_pkg::ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_result;
                    n_out_err   = r_err;
                    n_state     = lxrg_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = lxrg_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_axis_tready   = (r_state == lxrg_pkg::ST_IDLE);
    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_value;
    assign m_axis_tuser[0] = r_out_err;

endmodule

// ===== rtl/core/lxrg_checker.sv =====
// Port-level checks for lagged_xor_random_generator, attached by bind.
// Depends on lxrg_pkg for widths.
module lxrg_props (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [lxrg_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input logic [lxrg_pkg::REQ_W-1:0]     s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [lxrg_pkg::DATA_W-1:0]    m_axis_tdata,
    input logic [0:0]                     m_axis_tuser
);

    // Hold a stalled result valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // Hold a stalled result payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result payload changed while stalled");

    // One item at a time: ready drops after each accepted transaction
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while busy");

    // A new result appears only out of a busy cycle
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without a request in flight");

endmodule

bind lagged_xor_random_generator lxrg_props u_lxrg_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== dv/lxrg_checker.sv =====
// Scoreboard for the lagged XOR random generator: tracks the lag table, predicts each result.
// Watches both stream channels of lagged_xor_random_generator; depends on lxrg_pkg.
module lxrg_checker #(
    parameter int TABLE_SIZE = 249,
    parameter int TAP_START  = 103
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    // [31:0] seed_value, [63:32] range_low, [95:64] range_high
    input  logic [95:0]  s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] value
    input  logic [31:0]  m_axis_tdata,
    // [0] range_error
    input  logic [0:0]   m_axis_tuser,
    output int           o_pending,
    output int           o_fail_count
);

    // Seeding congruential step: x' = x * SEED_MUL + SEED_INC mod 2^32
    localparam logic [31:0] SEED_MUL = 32'h41C6_4E6D;
    localparam logic [31:0] SEED_INC = 32'h0000_3039;

    typedef struct packed {
        logic [31:0] value;
        logic        range_error;
    } t_draw_result;

    t_draw_result expected_draws[$];
    logic [30:0]  lag_words[TABLE_SIZE];
    int           rd_idx;
    int           tap_idx;
    int           fail_count;
    t_draw_result seen_draw;

    // Clear the table and both pointers, as reset does
    function automatic void clear_lag_state();
        for (int i = 0; i < TABLE_SIZE; i++) begin
            lag_words[i] = '0;
        end
        rd_idx  = 0;
        tap_idx = 0;
    endfunction

    // Refill every entry from two congruential steps, then rewind the pointers
    function automatic void reseed_lag_table(logic [31:0] seed);
        logic [31:0] j;
        logic [31:0] s;
        s = seed;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            j = s * SEED_MUL + SEED_INC;
            s = j * SEED_MUL + SEED_INC;
            lag_words[i] = {s[30:16], j[31:16]};
        end
        rd_idx  = 0;
        tap_idx = TAP_START % TABLE_SIZE;
    endfunction

    // XOR the two tapped entries, write back at the read pointer, advance both pointers
    function automatic logic [30:0] next_lag_word();
        logic [30:0] w;
        w = lag_words[rd_idx] ^ lag_words[tap_idx];
        lag_words[rd_idx] = w;
        rd_idx  = (rd_idx + 1 == TABLE_SIZE) ? 0 : rd_idx + 1;
        tap_idx = (tap_idx + 1 == TABLE_SIZE) ? 0 : tap_idx + 1;
        return w;
    endfunction

    // Work out the result of one request and update the table
    function automatic t_draw_result predict_draw(lxrg_pkg::t_req req, logic [31:0] seed,
                                                  logic [31:0] lo, logic [31:0] hi);
        t_draw_result r;
        logic [31:0]  span;
        logic [31:0]  w;
        r = '0;
        case (req)
            lxrg_pkg::REQ_SEED: begin
                reseed_lag_table(seed);
            end
            lxrg_pkg::REQ_RAW: begin
                r.value = {1'b0, next_lag_word()};
            end
            lxrg_pkg::REQ_RANGED: begin
                // empty range leaves table and pointers alone
                if ($signed(hi) <= $signed(lo)) begin
                    r.value       = lo;
                    r.range_error = 1'b1;
                end else begin
                    span    = hi - lo;
                    w       = {1'b0, next_lag_word()};
                    r.value = lo + w % span;
                end
            end
            default: begin
                // unused request code: no state change, zero result
            end
        endcase
        return r;
    endfunction

    // Count a failure; print only the first few
    function automatic void note_failure(string what, t_draw_result want, t_draw_result got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("[%0t] %s: expected value %h error %b, got value %h error %b",
                     $time, what, want.value, want.range_error, got.value, got.range_error);
        end
    endfunction

    // Check result transactions against the oldest expectation, then queue new ones
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_lag_state();
            expected_draws.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen_draw.value       = m_axis_tdata;
                seen_draw.range_error = m_axis_tuser[0];
                if (expected_draws.size() == 0) begin
                    note_failure("result with nothing outstanding", '0, seen_draw);
                end else if (expected_draws[0] !== seen_draw) begin
                    note_failure("result mismatch", expected_draws[0], seen_draw);
                    void'(expected_draws.pop_front());
                end else begin
                    void'(expected_draws.pop_front());
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_draws.push_back(predict_draw(lxrg_pkg::t_req'(s_axis_tuser),
                                                      s_axis_tdata[31:0],
                                                      s_axis_tdata[63:32],
                                                      s_axis_tdata[95:64]));
            end
        end
        o_pending    = expected_draws.size();
        o_fail_count = fail_count;
    end

endmodule

// ===== dv/lagged_xor_random_generator_tb.sv =====
// Testbench top for the lagged XOR random generator: clock, reset, request stimulus, verdict.
// Instantiates lagged_xor_random_generator and lxrg_checker; depends on lxrg_pkg.
module lagged_xor_random_generator_tb;

    localparam int TABLE_SIZE = 249;
    localparam int TAP_START  = 103;

    // Code with no defined request; the block must answer it with a zero result
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS  = 1830;
    localparam int IDLE_LIMIT    = 4000;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 2 * TABLE_SIZE + 40;

    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [31:0] seed_value, [63:32] range_low, [95:64] range_high
    logic [95:0] s_axis_tdata;
    // [1:0] req_type
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [31:0] value
    logic [31:0] m_axis_tdata;
    // [0] range_error
    logic [0:0]  m_axis_tuser;

    int   pending;
    int   fail_count;
    int   burst_left;
    int   hold_requests;

    lagged_xor_random_generator #(
        .TABLE_SIZE(TABLE_SIZE),
        .TAP_START (TAP_START)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    lxrg_checker #(
        .TABLE_SIZE(TABLE_SIZE),
        .TAP_START (TAP_START)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Receiver: ready pattern in phases, plus a long hold-off on request
    initial begin
        int   hold_left;
        int   hold_seen;
        int   phase_left;
        int   rx_mode;
        logic ready_next;
        hold_left     = 0;
        hold_seen     = 0;
        phase_left    = 0;
        rx_mode       = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else begin
                if (phase_left == 0) begin
                    rx_mode    = $urandom_range(0, 2);
                    phase_left = $urandom_range(20, 200);
                end
                phase_left--;
                case (rx_mode)
                    0:       ready_next = 1'b1;
                    1:       ready_next = 1'($urandom_range(0, 1));
                    default: ready_next = ($urandom_range(0, 3) == 0);
                endcase
            end
            m_axis_tready <= ready_next;
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Mismatches found");
        $finish;
    end

    // Offer one request and hold it until the block takes it
    task automatic offer_request(input logic [1:0] req, input logic [31:0] seed,
                                 input logic [31:0] lo, input logic [31:0] hi);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {hi, lo, seed};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Keep valid up inside a burst; drop it for a random gap between bursts
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 20)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(0, 8);
        end
    endtask

    // Stop offering and wait until every outstanding result has come back
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        logic [31:0] lo;
        logic [31:0] hi;
        logic [1:0]  req;
        int          pick;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        hold_requests = 0;
        burst_left    = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: draws on the cleared table, unused code, seed extremes, range edges
        offer_request(lxrg_pkg::REQ_RAW,    $urandom, $urandom, $urandom);
        offer_request(lxrg_pkg::REQ_RANGED, $urandom, -32'sd10, 32'sd10);
        offer_request(REQ_UNUSED, $urandom, $urandom, $urandom);
        offer_request(lxrg_pkg::REQ_SEED,   32'h0000_0000, $urandom, $urandom);
        pace_sender();
        offer_request(lxrg_pkg::REQ_RAW,    $urandom, $urandom, $urandom);
        offer_request(lxrg_pkg::REQ_RANGED, $urandom, INT_MIN, INT_MAX);
        offer_request(lxrg_pkg::REQ_RANGED, $urandom, 32'd5, 32'd6);
        offer_request(lxrg_pkg::REQ_RANGED, $urandom, 32'd7, 32'd7);
        pace_sender();
        offer_request(lxrg_pkg::REQ_RANGED, $urandom, INT_MAX, INT_MIN);
        offer_request(lxrg_pkg::REQ_RANGED, $urandom, 32'hFFFF_FFFF, 32'd0);
        offer_request(lxrg_pkg::REQ_SEED,   32'hFFFF_FFFF, $urandom, $urandom);
        offer_request(lxrg_pkg::REQ_RAW,    $urandom, $urandom, $urandom);
        offer_request(lxrg_pkg::REQ_RANGED, $urandom, INT_MIN, 32'd0);
        pace_sender();
        offer_request(lxrg_pkg::REQ_SEED,   INT_MIN, $urandom, $urandom);
        offer_request(lxrg_pkg::REQ_RAW,    $urandom, $urandom, $urandom);
        offer_request(lxrg_pkg::REQ_RANGED, $urandom, 32'd0, INT_MAX);
        offer_request(lxrg_pkg::REQ_SEED,   INT_MAX, $urandom, $urandom);
        offer_request(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_request(lxrg_pkg::REQ_RAW,    $urandom, $urandom, $urandom);
        offer_request(lxrg_pkg::REQ_RANGED, $urandom, INT_MIN, INT_MIN + 32'd1);
        drain_results();

        // Random: mostly draws between occasional reseeds
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            lo   = $urandom;
            hi   = $urandom;
            if (pick < 2) begin
                req = lxrg_pkg::REQ_SEED;
            end else if (pick < 5) begin
                req = REQ_UNUSED;
            end else if (pick < 50) begin
                req = lxrg_pkg::REQ_RAW;
            end else begin
                req = lxrg_pkg::REQ_RANGED;
                case ($urandom_range(0, 5))
                    0: ;
                    1: hi = lo + $urandom_range(1, 64);
                    2: hi = lo + ($urandom >> $urandom_range(0, 31));
                    3: hi = lo - $urandom_range(0, 3);
                    4: begin
                        lo = INT_MIN + $urandom_range(0, 3);
                        hi = INT_MAX - $urandom_range(0, 3);
                    end
                    default: begin
                        lo = -$urandom_range(0, 100);
                        hi = $urandom_range(1, 100);
                    end
                endcase
            end
            offer_request(req, $urandom, lo, hi);
            // back up the output side while requests keep coming
            if (n == 500 || n == 1300) begin
                hold_requests++;
            end
            if (n == 900) begin
                drain_results();
            end else begin
                pace_sender();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
